>>> rtl/core/aesinv_pkg.sv
// aes inverse cipher package: constants, tables and round functions
`default_nettype none
package aesinv_pkg;

  localparam int MAX_ROUND_KEYS = 15;
  localparam int KEY_IDX_W      = 4;
  localparam int BLOCK_W        = 128;

  typedef logic [BLOCK_W-1:0] block_t;
  typedef logic [KEY_IDX_W-1:0] key_idx_t;

  typedef enum logic [1:0] {
    MODE_AES128 = 2'd0,
    MODE_AES192 = 2'd1,
    MODE_AES256 = 2'd2
  } key_mode_t;

  typedef enum logic {
    FUNC_LOAD    = 1'b0,
    FUNC_DECRYPT = 1'b1
  } func_t;

  localparam logic [7:0] RSBOX_LUT [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic key_idx_t round_count(input logic [1:0] mode);
    key_idx_t nr;
    case (mode)
      MODE_AES128: nr = key_idx_t'(10);
      MODE_AES192: nr = key_idx_t'(12);
      default:     nr = key_idx_t'(14);
    endcase
    if (nr > key_idx_t'(MAX_ROUND_KEYS - 1)) nr = key_idx_t'(MAX_ROUND_KEYS - 1);
    return nr;
  endfunction

  function automatic logic [7:0] get_byte(input block_t s, input int n);
    return s[BLOCK_W-1-8*n -: 8];
  endfunction

  function automatic block_t unshift_unsub(input block_t s);
    block_t t;
    t = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[BLOCK_W-1-8*(r+4*((c+r)%4)) -: 8] = RSBOX_LUT[get_byte(s, r+4*c)];
      end
    end
    return t;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
  endfunction

  function automatic block_t unmix(input block_t s);
    block_t t;
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        a[i]  = get_byte(s, 4*c+i);
        x2[i] = xtime(a[i]);
        x4[i] = xtime(x2[i]);
        x8[i] = xtime(x4[i]);
        m9[i] = x8[i] ^ a[i];
        mb[i] = x8[i] ^ x2[i] ^ a[i];
        md[i] = x8[i] ^ x4[i] ^ a[i];
        me[i] = x8[i] ^ x4[i] ^ x2[i];
      end
      t[BLOCK_W-1-8*(4*c)   -: 8] = me[0] ^ mb[1] ^ md[2] ^ m9[3];
      t[BLOCK_W-1-8*(4*c+1) -: 8] = m9[0] ^ me[1] ^ mb[2] ^ md[3];
      t[BLOCK_W-1-8*(4*c+2) -: 8] = md[0] ^ m9[1] ^ me[2] ^ mb[3];
      t[BLOCK_W-1-8*(4*c+3) -: 8] = mb[0] ^ md[1] ^ m9[2] ^ me[3];
    end
    return t;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/aes_inverse_cipher_unit.sv
// aes inverse cipher unit: fifteen-stage decryption pipeline with round key registers
//
// input channel in_valid/in_ready carries func, key_slot and a 128-bit block.
// func load writes the block as round key key_slot (slots 15 and up are dropped),
// func decrypt runs the inverse cipher and gives one plaintext on out_valid/out_ready.
// one stage per round key, from key 14 down to key 0; stages above the round count
// of the key length pass the block through, so every result goes through all the stage
// registers in order, whatever the key length, before it shows at the output register.
// without a stall an item can enter every cycle, so throughput is one item per cycle.
// a load travels the pipeline and writes its key as it enters that key's stage,
// which keeps it ordered against decrypts ahead and behind it.
// cfg_write_enable/cfg_write_data set key_length_mode; write only while idle.
// when the receiver stalls with a result waiting, the whole pipeline holds and
// in_ready drops; nothing is lost or repeated.
// reset (rst_n low, synchronous) empties the pipeline and sets AES-128;
// round keys are undefined until loaded.
`default_nettype none
module aes_inverse_cipher_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_write_enable,
  input  wire logic [1:0]  cfg_write_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_func,
  input  wire logic [3:0]  in_key_slot,
  input  wire logic [63:0] in_block_high,
  input  wire logic [63:0] in_block_low,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_plain_high,
  output logic [63:0]      out_plain_low
);

  localparam int NK = aesinv_pkg::MAX_ROUND_KEYS;

  logic [1:0]              mode_r;
  logic [NK-1:0]           v_r;
  logic [NK-1:0]           load_r;
  aesinv_pkg::key_idx_t    slot_r [NK];
  aesinv_pkg::block_t      data_r [NK];
  aesinv_pkg::block_t      key_r  [NK];
  aesinv_pkg::key_idx_t    nr;
  logic                    adv;

  assign nr       = aesinv_pkg::round_count(mode_r);
  assign out_valid = v_r[0] && !load_r[0];
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign out_plain_high = data_r[0][127:64];
  assign out_plain_low  = data_r[0][63:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= aesinv_pkg::MODE_AES128;
    end else if (cfg_write_enable) begin
      mode_r <= cfg_write_data;
    end
  end

  for (genvar k = 0; k < NK; k++) begin : g_stage
    logic                 v_in;
    logic                 load_in;
    aesinv_pkg::key_idx_t slot_in;
    aesinv_pkg::block_t   d_in;
    aesinv_pkg::block_t   d_nxt;

    if (k == NK - 1) begin : g_head
      assign v_in    = in_valid;
      assign load_in = (in_func == aesinv_pkg::FUNC_LOAD);
      assign slot_in = in_key_slot;
      assign d_in    = {in_block_high, in_block_low};
    end else begin : g_body
      assign v_in    = v_r[k+1];
      assign load_in = load_r[k+1];
      assign slot_in = slot_r[k+1];
      assign d_in    = data_r[k+1];
    end

    always_comb begin
      if (load_in || (aesinv_pkg::key_idx_t'(k) > nr)) begin
        d_nxt = d_in;
      end else if (aesinv_pkg::key_idx_t'(k) == nr) begin
        d_nxt = d_in ^ key_r[k];
      end else if (k == 0) begin
        d_nxt = aesinv_pkg::unshift_unsub(d_in) ^ key_r[k];
      end else begin
        d_nxt = aesinv_pkg::unmix(aesinv_pkg::unshift_unsub(d_in) ^ key_r[k]);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        load_r[k] <= load_in;
        slot_r[k] <= slot_in;
        data_r[k] <= d_nxt;
        if (v_in && load_in && (slot_in == aesinv_pkg::key_idx_t'(k))) begin
          key_r[k] <= d_in;
        end
      end
    end
  end

  // stall freezes the pipeline
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v_r) && $stable(data_r[0]))
    else $error("pipeline moved during stall");

  // a load for the top slot lands in its key register
  a_key_top: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == aesinv_pkg::FUNC_LOAD)
      && (in_key_slot == aesinv_pkg::key_idx_t'(NK - 1))
    |=> key_r[NK-1] == $past({in_block_high, in_block_low}))
    else $error("round key write missed");

  // accepted item reaches the first stage register
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v_r[NK-1])
    else $error("transfer lost at pipeline entry");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    !rst_n |=> (v_r == '0))
    else $error("pipeline not empty after reset");

endmodule
`default_nettype wire

>>> tb/sv/aes_inverse_cipher_unit_test.sv
// testbench for the aes inverse cipher unit: keyed decrypts checked against a local predictor
`timescale 1ns / 100ps
module aes_inverse_cipher_unit_test;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 24;

  logic        clk;
  logic        rst_n;
  logic        cfg_write_enable;
  logic [1:0]  cfg_write_data;
  logic        in_valid;
  logic        in_ready;
  logic        in_func;
  logic [3:0]  in_key_slot;
  logic [63:0] in_block_high;
  logic [63:0] in_block_low;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_plain_high;
  logic [63:0] out_plain_low;

  aes_inverse_cipher_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_key_slot      (in_key_slot),
    .in_block_high    (in_block_high),
    .in_block_low     (in_block_low),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_plain_high   (out_plain_high),
    .out_plain_low    (out_plain_low)
  );

  logic [127:0] key_store [aesinv_pkg::MAX_ROUND_KEYS];
  logic [1:0]   key_mode;
  logic [127:0] plain_queue [$];
  int           error_count = 0;
  int           cycle_count = 0;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [7:0] gf_mult(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[0]) p = p ^ a;
      a = a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
      b = b >> 1;
    end
    return p;
  endfunction

  function automatic logic [127:0] inv_rows_bytes(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        t[127-8*(r+4*((c+r)%4)) -: 8] = aesinv_pkg::RSBOX_LUT[s[127-8*(r+4*c) -: 8]];
    return t;
  endfunction

  function automatic logic [127:0] inv_columns(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0]   a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-8*(4*c) -: 8];
      a1 = s[127-8*(4*c+1) -: 8];
      a2 = s[127-8*(4*c+2) -: 8];
      a3 = s[127-8*(4*c+3) -: 8];
      t[127-8*(4*c) -: 8] = gf_mult(a0, 8'd14) ^ gf_mult(a1, 8'd11)
                            ^ gf_mult(a2, 8'd13) ^ gf_mult(a3, 8'd9);
      t[127-8*(4*c+1) -: 8] = gf_mult(a0, 8'd9) ^ gf_mult(a1, 8'd14)
                              ^ gf_mult(a2, 8'd11) ^ gf_mult(a3, 8'd13);
      t[127-8*(4*c+2) -: 8] = gf_mult(a0, 8'd13) ^ gf_mult(a1, 8'd9)
                              ^ gf_mult(a2, 8'd14) ^ gf_mult(a3, 8'd11);
      t[127-8*(4*c+3) -: 8] = gf_mult(a0, 8'd11) ^ gf_mult(a1, 8'd13)
                              ^ gf_mult(a2, 8'd9) ^ gf_mult(a3, 8'd14);
    end
    return t;
  endfunction

  function automatic logic [127:0] decrypt_block(input logic [127:0] ct);
    logic [127:0] s;
    int           nr;
    case (key_mode)
      aesinv_pkg::MODE_AES128: nr = 10;
      aesinv_pkg::MODE_AES192: nr = 12;
      default:                 nr = 14;
    endcase
    if (nr > aesinv_pkg::MAX_ROUND_KEYS - 1) nr = aesinv_pkg::MAX_ROUND_KEYS - 1;
    s = ct ^ key_store[nr];
    for (int r = nr - 1; r > 0; r--)
      s = inv_columns(inv_rows_bytes(s) ^ key_store[r]);
    return inv_rows_bytes(s) ^ key_store[0];
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_item(input aesinv_pkg::func_t func, input logic [3:0] slot,
                           input logic [63:0] hi, input logic [63:0] lo);
    int gap;
    gap = $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= func;
    in_key_slot   <= slot;
    in_block_high <= hi;
    in_block_low  <= lo;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    if (func == aesinv_pkg::FUNC_LOAD) begin
      if (slot < aesinv_pkg::MAX_ROUND_KEYS) key_store[slot] = {hi, lo};
    end else begin
      plain_queue.push_back(decrypt_block({hi, lo}));
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (plain_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_key_mode(input logic [1:0] mode);
    wait_idle();
    cfg_write_enable <= 1'b1;
    cfg_write_data   <= mode;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    key_mode = mode;
  endtask

  task automatic load_all_keys();
    for (int k = 0; k < aesinv_pkg::MAX_ROUND_KEYS; k++)
      send_item(aesinv_pkg::FUNC_LOAD, 4'(k), rand64(), rand64());
  endtask

  task automatic test_key_extremes();
    for (int k = 0; k < aesinv_pkg::MAX_ROUND_KEYS; k++)
      send_item(aesinv_pkg::FUNC_LOAD, 4'(k), '0, '0);
    send_item(aesinv_pkg::FUNC_DECRYPT, 4'd0, '0, '0);
    send_item(aesinv_pkg::FUNC_DECRYPT, 4'd15, '1, '1);
    for (int k = 0; k < aesinv_pkg::MAX_ROUND_KEYS; k++)
      send_item(aesinv_pkg::FUNC_LOAD, 4'(k), '1, '1);
    send_item(aesinv_pkg::FUNC_DECRYPT, 4'd7, '0, '1);
    send_item(aesinv_pkg::FUNC_DECRYPT, 4'd8, '1, '0);
  endtask

  // loads to slot 15 must be dropped
  task automatic test_slot_out_of_range();
    send_item(aesinv_pkg::FUNC_LOAD, 4'd15, rand64(), rand64());
    send_item(aesinv_pkg::FUNC_DECRYPT, 4'd0, rand64(), rand64());
  endtask

  task automatic test_key_modes();
    load_all_keys();
    for (int m = 0; m < 4; m++) begin
      set_key_mode(2'(m));
      for (int i = 0; i < 3; i++)
        send_item(aesinv_pkg::FUNC_DECRYPT, 4'($urandom_range(0, 15)), rand64(), rand64());
    end
    set_key_mode(aesinv_pkg::MODE_AES128);
  endtask

  task automatic test_random_traffic();
    logic [3:0] slot;
    for (int i = 0; i < 700; i++) begin
      if (i % 150 == 149) set_key_mode(2'($urandom_range(0, 3)));
      if (i == 300) wait_idle();
      if ($urandom_range(0, 4) == 0) begin
        slot = 4'($urandom_range(0, 15));
        send_item(aesinv_pkg::FUNC_LOAD, slot, rand64(), rand64());
      end else begin
        send_item(aesinv_pkg::FUNC_DECRYPT, 4'($urandom_range(0, 15)), rand64(), rand64());
      end
    end
  endtask

  initial begin
    logic [127:0] got;
    logic [127:0] want;
    int           stall;
    out_ready = 1'b0;
    forever begin
      stall = $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(negedge clk);
      while (!(out_valid && rst_n)) @(negedge clk);
      got = {out_plain_high, out_plain_low};
      @(posedge clk);
      if (plain_queue.size() == 0) begin
        error_count++;
        if (error_count <= 10) $display("unexpected result %h", got);
      end else begin
        want = plain_queue.pop_front();
        if (got[127:64] !== want[127:64] || got[63:0] !== want[63:0]) begin
          error_count++;
          if (error_count <= 10)
            $display("plaintext mismatch: expected %h_%h actual %h_%h",
                     want[127:64], want[63:0], got[127:64], got[63:0]);
        end
      end
    end
  end

  initial begin
    key_mode         = aesinv_pkg::MODE_AES128;
    rst_n            = 1'b0;
    cfg_write_enable = 1'b0;
    cfg_write_data   = 2'd0;
    in_valid         = 1'b0;
    in_func          = aesinv_pkg::FUNC_LOAD;
    in_key_slot      = 4'd0;
    in_block_high    = '0;
    in_block_low     = '0;
    for (int k = 0; k < aesinv_pkg::MAX_ROUND_KEYS; k++) key_store[k] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_key_extremes();
    test_slot_out_of_range();
    test_key_modes();
    test_random_traffic();
    wait_idle();
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
